// ===== rtl/pfc_pkg.sv =====
// Package for the prime / Fibonacci classifier.
// Holds the default width, the controller state type and the command and
// status structs shared by the controller and the datapath.
`timescale 1ns / 1ps

package pfc_pkg;

  localparam int VALUE_BITS_DEF = 14;

  typedef enum logic [2:0] {
    PFC_IDLE,
    PFC_CHECK,
    PFC_DIV,
    PFC_REM,
    PFC_WAIT
  } pfc_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic next_div;
    logic set_prime;
    logic prime_val;
    logic emit;
  } pfc_cmd_t;

  typedef struct packed {
    logic lt_two;
    logic sq_gt_val;
    logic div_last;
    logic rem_zero;
    logic fib_done;
    logic out_free;
  } pfc_sts_t;

endpackage

// ===== rtl/pfc_ctrl.sv =====
// Controller for the prime / Fibonacci classifier.
// Sequences the trial-division loop and the result transfer; uses pfc_pkg.
`timescale 1ns / 1ps

module pfc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfc_pkg::pfc_sts_t  sts,
  output pfc_pkg::pfc_cmd_t  cmd,
  output pfc_pkg::pfc_state_t state
);

  pfc_pkg::pfc_state_t state_r;
  pfc_pkg::pfc_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfc_pkg::PFC_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfc_pkg::PFC_IDLE: begin
        if (in_valid) state_nxt = pfc_pkg::PFC_CHECK;
      end
      pfc_pkg::PFC_CHECK: begin
        if (sts.lt_two || sts.sq_gt_val) state_nxt = pfc_pkg::PFC_WAIT;
        else state_nxt = pfc_pkg::PFC_DIV;
      end
      pfc_pkg::PFC_DIV: begin
        if (sts.div_last) state_nxt = pfc_pkg::PFC_REM;
      end
      pfc_pkg::PFC_REM: begin
        if (sts.rem_zero) state_nxt = pfc_pkg::PFC_WAIT;
        else state_nxt = pfc_pkg::PFC_CHECK;
      end
      pfc_pkg::PFC_WAIT: begin
        if (sts.fib_done && sts.out_free) state_nxt = pfc_pkg::PFC_IDLE;
      end
      default: state_nxt = pfc_pkg::PFC_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      pfc_pkg::PFC_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      pfc_pkg::PFC_CHECK: begin
        if (sts.lt_two || sts.sq_gt_val) begin
          // no divisor left to try: prime unless below two
          cmd.set_prime = 1'b1;
          cmd.prime_val = !sts.lt_two;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      pfc_pkg::PFC_DIV: begin
        cmd.div_step = 1'b1;
      end
      pfc_pkg::PFC_REM: begin
        if (sts.rem_zero) begin
          cmd.set_prime = 1'b1;
          cmd.prime_val = 1'b0;
        end else begin
          cmd.next_div = 1'b1;
        end
      end
      pfc_pkg::PFC_WAIT: begin
        cmd.emit = sts.fib_done && sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign state = state_r;

endmodule

// ===== rtl/pfc_dpath.sv =====
// Datapath for the prime / Fibonacci classifier: bit-serial remainder unit,
// divisor and square tracking, Fibonacci walk and output register; uses pfc_pkg.
`timescale 1ns / 1ps

module pfc_dpath #(
  parameter int VALUE_BITS = pfc_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [VALUE_BITS-1:0] in_value,
  input  pfc_pkg::pfc_cmd_t     cmd,
  output pfc_pkg::pfc_sts_t     sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_is_prime,
  output logic                  out_is_fibonacci,
  output logic [1:0]            out_rank
);

  localparam int W     = VALUE_BITS;
  localparam int IDX_W = $clog2(VALUE_BITS);

  logic [W-1:0]     value_r, value_nxt;
  logic [W-1:0]     div_r, div_nxt;
  logic [W:0]       sq_r, sq_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [W+1:0]     fa_r, fa_nxt;
  logic [W+1:0]     fb_r, fb_nxt;
  logic             fib_done_r, fib_done_nxt;
  logic             fib_hit_r, fib_hit_nxt;
  logic             prime_r, prime_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_prime_r, out_prime_nxt;
  logic             out_fib_r, out_fib_nxt;
  logic [1:0]       out_rank_r, out_rank_nxt;

  logic [W:0]       rem_sh;
  logic [W:0]       rem_diff;
  logic             out_free;

  // one restoring-division step: shift in the next dividend bit
  assign rem_sh   = {rem_r, value_r[idx_r]};
  assign rem_diff = rem_sh - {1'b0, div_r};
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    value_nxt = value_r;
    div_nxt   = div_r;
    sq_nxt    = sq_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    prime_nxt = prime_r;
    if (cmd.load) begin
      value_nxt = in_value;
      div_nxt   = W'(2);
      sq_nxt    = (W+1)'(4);
    end
    if (cmd.div_start) begin
      rem_nxt = '0;
      idx_nxt = IDX_W'(W - 1);
    end
    if (cmd.div_step) begin
      rem_nxt = (rem_sh >= {1'b0, div_r}) ? rem_diff[W-1:0] : rem_sh[W-1:0];
      idx_nxt = idx_r - IDX_W'(1);
    end
    if (cmd.next_div) begin
      // (d+1)^2 = d^2 + 2d + 1
      sq_nxt  = sq_r + {div_r, 1'b1};
      div_nxt = div_r + W'(1);
    end
    if (cmd.set_prime) prime_nxt = cmd.prime_val;
  end

  // Fibonacci walk runs alongside the division loop
  always_comb begin
    fa_nxt       = fa_r;
    fb_nxt       = fb_r;
    fib_done_nxt = fib_done_r;
    fib_hit_nxt  = fib_hit_r;
    if (cmd.load) begin
      fa_nxt       = '0;
      fb_nxt       = (W+2)'(1);
      fib_done_nxt = 1'b0;
      fib_hit_nxt  = 1'b0;
    end else if (!fib_done_r) begin
      if (fa_r == {2'b00, value_r}) begin
        fib_done_nxt = 1'b1;
        fib_hit_nxt  = 1'b1;
      end else if (fa_r > {2'b00, value_r}) begin
        fib_done_nxt = 1'b1;
      end else begin
        fa_nxt = fb_r;
        fb_nxt = fa_r + fb_r;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_prime_nxt = out_prime_r;
    out_fib_nxt   = out_fib_r;
    out_rank_nxt  = out_rank_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_prime_nxt = prime_r;
      out_fib_nxt   = fib_hit_r;
      out_rank_nxt  = {1'b0, prime_r} + {1'b0, fib_hit_r};
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fib_done_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      fib_done_r  <= fib_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r     <= value_nxt;
    div_r       <= div_nxt;
    sq_r        <= sq_nxt;
    rem_r       <= rem_nxt;
    idx_r       <= idx_nxt;
    fa_r        <= fa_nxt;
    fb_r        <= fb_nxt;
    fib_hit_r   <= fib_hit_nxt;
    prime_r     <= prime_nxt;
    out_prime_r <= out_prime_nxt;
    out_fib_r   <= out_fib_nxt;
    out_rank_r  <= out_rank_nxt;
  end

  always_comb begin
    sts.lt_two    = value_r < W'(2);
    sts.sq_gt_val = sq_r > {1'b0, value_r};
    sts.div_last  = idx_r == '0;
    sts.rem_zero  = rem_r == '0;
    sts.fib_done  = fib_done_r;
    sts.out_free  = out_free;
  end

  assign out_valid        = out_valid_r;
  assign out_is_prime     = out_prime_r;
  assign out_is_fibonacci = out_fib_r;
  assign out_rank         = out_rank_r;

endmodule

// ===== rtl/prime_fibonacci_classifier.sv =====
// Top level of the prime / Fibonacci classifier.
// Joins pfc_ctrl and pfc_dpath; uses pfc_pkg.
//
// Usage: present a number on in_value with in_valid; it is taken on a clock
// edge where in_stall is low. One result (out_is_prime, out_is_fibonacci,
// out_rank) follows on the out_ channel for each transfer in.
// Primality is trial division over divisors d = 2, 3, ... while d*d <= value,
// each remainder formed by a bit-serial divider at one bit per cycle.
// Each candidate takes a check, VALUE_BITS division steps and a remainder test.
// The search stops at the first divisor that divides evenly, so a prime is
// slowest. The Fibonacci walk (one sequence term per cycle) runs alongside
// and the result waits for both; the walk sets the time for small values
// and values with a small factor. One item is worked on at a time; the next
// is taken once the result has moved into the output register.
// Reset (rst_n low at a clock edge) returns the controller to idle and drops
// any pending result. A stalled result holds in the output register while
// the next item is already taken and computed; that item then waits until
// the register frees up.
`timescale 1ns / 1ps

module prime_fibonacci_classifier #(
  parameter int VALUE_BITS = pfc_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_is_prime,
  output logic                  out_is_fibonacci,
  output logic [1:0]            out_rank
);

  pfc_pkg::pfc_cmd_t   cmd;
  pfc_pkg::pfc_sts_t   sts;
  pfc_pkg::pfc_state_t state;

  pfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  pfc_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_value         (in_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_prime     (out_is_prime),
    .out_is_fibonacci (out_is_fibonacci),
    .out_rank         (out_rank)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state == pfc_pkg::PFC_CHECK))
    else $error("accepted item did not start the divisor check");

  a_emit_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (sts.fib_done && sts.out_free))
    else $error("result emitted before Fibonacci walk done or slot free");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (out_valid && out_rank != 2'd3))
    else $error("emitted result not presented or rank out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !cmd.emit)
    else $error("stalled result overwritten");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for prime_fibonacci_classifier: classifies each number
// with its own trial-division and perfect-square predictor and checks every
// out_ transfer against it. Depends on pfc_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;

  localparam int VALUE_BITS   = pfc_pkg::VALUE_BITS_DEF;
  localparam int MAX_VALUE    = (1 << VALUE_BITS) - 1;
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int TAIL_CYCLES  = 2200;
  localparam int RANDOM_ITEMS = 116;

  typedef struct {
    int         value;
    logic       is_prime;
    logic       is_fib;
    logic [1:0] rank;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_is_prime;
  logic                  out_is_fibonacci;
  logic [1:0]            out_rank;

  int       pending_values[$];
  verdict_t expected_verdicts[$];
  int       fib_numbers[$];
  int       sent_count = 0;
  int       total_items = 1;
  int       errors = 0;
  int       cycles = 0;

  prime_fibonacci_classifier uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_prime     (out_is_prime),
    .out_is_fibonacci (out_is_fibonacci),
    .out_rank         (out_rank)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // largest r with r*r <= n, by binary search
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'd1 << 32;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= n) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic bit perfect_square(longint unsigned n);
    longint unsigned r;
    r = floor_sqrt(n);
    return r * r == n;
  endfunction

  function automatic verdict_t predict_verdict(logic [VALUE_BITS-1:0] v);
    verdict_t        res;
    longint unsigned x;
    longint unsigned five_sq;
    longint unsigned d;
    x = v;
    res.value = v;
    res.is_prime = (x >= 2);
    for (d = 2; d * d <= x && res.is_prime; d++) begin
      if (x % d == 0) res.is_prime = 1'b0;
    end
    five_sq = 5 * x * x;
    // the minus-four candidate only exists once 5x^2 reaches four
    res.is_fib = perfect_square(five_sq + 4) ||
                 (five_sq >= 4 && perfect_square(five_sq - 4));
    res.rank = 2'(res.is_prime) + 2'(res.is_fib);
    return res;
  endfunction

  // idle percentage per phase: sender light / receiver heavy, then swapped, then none
  function automatic int idle_pct(bit sender_side);
    int phase;
    phase = sent_count * 3 / total_items;
    case (phase)
      0: begin
        return sender_side ? 36 : 79;
      end
      1: begin
        return sender_side ? 79 : 36;
      end
      default: begin
        return 0;
      end
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    int  next_count;
    bit  drain_hold;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_count = sent_count;
      if (in_valid && !in_stall) begin
        expected_verdicts.push_back(predict_verdict(in_value));
        next_count = sent_count + 1;
        sent_count <= next_count;
      end
      // hold off twice until the block has delivered everything
      drain_hold = (next_count == 60 || next_count == 120) &&
                   expected_verdicts.size() != 0;
      if (!in_valid || !in_stall) begin
        if (pending_values.size() != 0 && !drain_hold &&
            $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          in_valid <= 1'b1;
          in_value <= VALUE_BITS'(pending_values.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, got prime %0b fib %0b rank %0d",
                 $time, out_is_prime, out_is_fibonacci, out_rank);
        errors++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_is_prime !== want.is_prime) begin
          $display("%0t: value %0d is_prime expected %0b got %0b",
                   $time, want.value, want.is_prime, out_is_prime);
          errors++;
        end
        if (out_is_fibonacci !== want.is_fib) begin
          $display("%0t: value %0d is_fibonacci expected %0b got %0b",
                   $time, want.value, want.is_fib, out_is_fibonacci);
          errors++;
        end
        if (out_rank !== want.rank) begin
          $display("%0t: value %0d rank expected %0d got %0d",
                   $time, want.value, want.rank, out_rank);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < idle_pct(1'b0));
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int a;
    int b;
    int t;
    int sel;
    int v;
    a = 0;
    b = 1;
    while (a <= MAX_VALUE) begin
      fib_numbers.push_back(a);
      t = a + b;
      a = b;
      b = t;
    end

    // zero and one, small primes and composites, squares, Fibonacci primes
    // and composites, the widest values
    pending_values = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 13, 21, 89, 121, 144, 169,
                       233, 1597, 4181, 10946, 8192, 127, 16381, MAX_VALUE};
    repeat (RANDOM_ITEMS) begin
      sel = $urandom_range(0, 3);
      case (sel)
        0: begin
          v = fib_numbers[$urandom_range(0, fib_numbers.size() - 1)];
          // also land next to a Fibonacci number now and then
          if ($urandom_range(0, 2) == 0) v = (v == 0) ? 1 : v - 1;
        end
        1: begin
          v = $urandom_range(0, 63);
        end
        2: begin
          v = $urandom_range(0, 1023);
        end
        default: begin
          v = $urandom_range(0, MAX_VALUE);
        end
      endcase
      pending_values.push_back(v);
    end
    total_items = pending_values.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_values.size() != 0 || in_valid || expected_verdicts.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
